FILE: hw/rtl/dsp_pkg.sv
// Shared types, constants and codes of the shortest path search block.
package dsp_pkg;

   // Default matrix size, handed to the top level parameter.
   localparam int MAX_VERTICES_DEF = 16;

   // Vertex fields are 4 bits wide, so at most this many vertices take part in a search.
   localparam int FIELD_SPAN = 16;
   localparam int VIDX_W     = 4;
   localparam int CNT_W      = 5;
   localparam int DIST_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [DIST_W-1:0] LIMIT_RESET = 16'd1000;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 5'd16;
   localparam logic [CNT_W-1:0]  COUNT_MIN   = 5'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT = 1'b1;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_RUN   = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [VIDX_W-1:0]       row;
      logic [VIDX_W-1:0]       col;
      logic [DIST_W-1:0]       weight;
      logic [VIDX_W-1:0]       start_vertex;
   } req_word_type;

   typedef struct packed {
      logic [VIDX_W-1:0]       vertex;
      logic                    reachable;
      logic [DIST_W-1:0]       distance;
      logic [VIDX_W-1:0]       predecessor;
      logic                    last;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic edge_wr;
      logic load_run;
      logic scan_en;
      logic next_pass;
      logic emit_init;
      logic emit_en;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic start_ok;
      logic scan_done;
      logic found;
      logic emit_done;
      logic out_free;
   } ctl_status_type;

endpackage

FILE: hw/rtl/dsp_if.sv
// Valid/ready channel interfaces for the request and response words.
interface dsp_req_if;
   import dsp_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [VIDX_W-1:0]   row;
   logic [VIDX_W-1:0]   col;
   logic [DIST_W-1:0]   weight;
   logic [VIDX_W-1:0]   start_vertex;

   modport source (
      output valid, opcode, row, col, weight, start_vertex,
      input  ready
   );

   modport sink (
      input  valid, opcode, row, col, weight, start_vertex,
      output ready
   );
endinterface

interface dsp_rsp_if;
   import dsp_pkg::*;

   logic                valid;
   logic                ready;
   logic [VIDX_W-1:0]   vertex;
   logic                reachable;
   logic [DIST_W-1:0]   distance;
   logic [VIDX_W-1:0]   predecessor;
   logic                last;

   modport source (
      output valid, vertex, reachable, distance, predecessor, last,
      input  ready
   );

   modport sink (
      input  valid, vertex, reachable, distance, predecessor, last,
      output ready
   );
endinterface

FILE: hw/rtl/dsp_ctrl.sv
// Controller state machine of the shortest path search block.
module dsp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  dsp_pkg::opcode_type      req_opcode,
   output logic                     req_ready,
   input  dsp_pkg::ctl_status_type  status,
   output dsp_pkg::ctl_cmd_type     cmd
);
   import dsp_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_WRITE) begin
                  cmd.edge_wr = 1'b1;
               end else if (status.start_ok) begin
                  cmd.load_run = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               if (status.found) begin
                  cmd.next_pass = 1'b1;
               end else begin
                  cmd.emit_init = 1'b1;
                  state_in      = ST_EMIT;
               end
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_en = 1'b1;
               if (status.emit_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/dsp_datapath.sv
// Datapath: adjacency memory, distance tables, scan pipeline and response register.
module dsp_datapath #(
   parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dsp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  dsp_pkg::req_word_type                req_word,
   input  dsp_pkg::ctl_cmd_type                 cmd,
   output dsp_pkg::ctl_status_type              status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output dsp_pkg::rsp_word_type                rsp_word
);
   import dsp_pkg::*;

   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CAP   = (MAX_VERTICES < FIELD_SPAN) ? MAX_VERTICES : FIELD_SPAN;
   localparam logic [CNT_W-1:0] CAP_N     = CNT_W'(CAP);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

   // Configuration registers.
   logic [DIST_W-1:0] limit_ff;
   logic [CNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_LIMIT: limit_ff <= csr_wdata[DIST_W-1:0];
            REG_COUNT: count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Vertices in use: at least COUNT_MIN, at most what the storage and fields allow.
   logic [CNT_W-1:0] n_used;

   always_comb begin
      if (count_ff < COUNT_MIN) begin
         n_used = COUNT_MIN;
      end else if (count_ff > CAP_N) begin
         n_used = CAP_N;
      end else begin
         n_used = count_ff;
      end
   end

   // Scan and emit state.
   logic [AW-1:0]            clr_ff, clr_in;
   logic [CNT_W-1:0]         u_ff, u_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [VIDX_W-1:0]        s1_u_ff, s1_u_in;
   logic [VIDX_W-1:0]        cur_v_ff, cur_v_in;
   logic [DIST_W-1:0]        cur_dist_ff, cur_dist_in;
   logic                     first_ff, first_in;
   logic [DIST_W-1:0]        best_ff, best_in;
   logic [VIDX_W-1:0]        next_ff, next_in;
   logic                     found_ff, found_in;
   logic [VIDX_W-1:0]        start_ff, start_in;
   logic [FIELD_SPAN-1:0]    settled_ff, settled_in;
   logic [CNT_W-1:0]         e_ff, e_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             out_word_ff, out_word_in;

   logic [DIST_W-1:0]        dist_ff [FIELD_SPAN];
   logic [VIDX_W-1:0]        pred_ff [FIELD_SPAN];

   // Adjacency memory: one write port, one registered read port.
   logic [DIST_W-1:0]        adj_mem [DEPTH];
   logic [DIST_W-1:0]        adj_q_ff;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DIST_W-1:0]        wr_data;
   logic [AW-1:0]            rd_addr;
   logic                     edge_in_range;

   assign edge_in_range = (32'(req_word.row) < MAX_VERTICES) &&
                          (32'(req_word.col) < MAX_VERTICES);

   always_comb begin
      if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.edge_wr && edge_in_range;
         wr_addr = AW'(32'(req_word.row) * MAX_VERTICES + 32'(req_word.col));
         wr_data = req_word.weight;
      end
   end

   assign rd_addr = AW'(32'(cur_v_ff) * MAX_VERTICES + 32'(u_ff[VIDX_W-1:0]));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      adj_q_ff <= adj_mem[rd_addr];
   end

   // Relaxation and minimum search on the word that left the memory.
   logic [VIDX_W-1:0]   rd_idx;
   logic [DIST_W-1:0]   dist_rd;
   logic [DIST_W-1:0]   old_d;
   logic [DIST_W:0]     sum;
   logic                relax;
   logic [DIST_W-1:0]   new_d;
   logic                better;
   logic                issue;
   logic                is_start;
   logic                reach;
   logic                last_res;

   assign rd_idx  = s1_valid_ff ? s1_u_ff : e_ff[VIDX_W-1:0];
   assign dist_rd = dist_ff[rd_idx];
   assign old_d   = first_ff ? limit_ff : dist_rd;
   assign sum     = {1'b0, cur_dist_ff} + {1'b0, adj_q_ff};
   assign relax   = s1_valid_ff && (adj_q_ff != '0) && !settled_ff[s1_u_ff] &&
                    ({1'b0, old_d} > sum);
   assign new_d   = relax ? sum[DIST_W-1:0] : old_d;
   assign better  = s1_valid_ff && !settled_ff[s1_u_ff] && (new_d < best_ff);
   assign issue   = cmd.scan_en && (u_ff < n_used);

   assign is_start = (e_ff[VIDX_W-1:0] == start_ff);
   assign reach    = settled_ff[e_ff[VIDX_W-1:0]];
   assign last_res = (e_ff == n_used - CNT_W'(1)) ||
                     ((e_ff == n_used - CNT_W'(2)) &&
                      ({1'b0, start_ff} == n_used - CNT_W'(1)));

   always_comb begin
      clr_in       = cmd.clear_en ? clr_ff + AW'(1) : clr_ff;
      u_in         = u_ff;
      s1_valid_in  = issue;
      s1_u_in      = u_ff[VIDX_W-1:0];
      cur_v_in     = cur_v_ff;
      cur_dist_in  = cur_dist_ff;
      first_in     = first_ff;
      best_in      = best_ff;
      next_in      = next_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      settled_in   = settled_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff;
      out_word_in  = out_word_ff;

      if (cmd.load_run) begin
         start_in    = req_word.start_vertex;
         cur_v_in    = req_word.start_vertex;
         cur_dist_in = '0;
         first_in    = 1'b1;
         u_in        = '0;
         best_in     = limit_ff;
         next_in     = '0;
         found_in    = 1'b0;
         settled_in  = FIELD_SPAN'(1) << req_word.start_vertex;
      end else if (cmd.next_pass) begin
         cur_v_in    = next_ff;
         cur_dist_in = best_ff;
         first_in    = 1'b0;
         u_in        = '0;
         best_in     = limit_ff;
         found_in    = 1'b0;
         settled_in  = settled_ff | (FIELD_SPAN'(1) << next_ff);
      end else begin
         if (issue) begin
            u_in = u_ff + CNT_W'(1);
         end
         if (better) begin
            best_in  = new_d;
            next_in  = s1_u_ff;
            found_in = 1'b1;
         end
      end

      if (cmd.emit_init) begin
         e_in = '0;
      end else if (cmd.emit_en) begin
         e_in = e_ff + CNT_W'(1);
      end

      if (cmd.emit_en && !is_start) begin
         rsp_valid_in            = 1'b1;
         out_word_in.vertex      = e_ff[VIDX_W-1:0];
         out_word_in.reachable   = reach;
         out_word_in.distance    = reach ? dist_rd : limit_ff;
         out_word_in.predecessor = reach ? pred_ff[e_ff[VIDX_W-1:0]] : '0;
         out_word_in.last        = last_res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         u_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         first_ff     <= 1'b0;
         found_ff     <= 1'b0;
         settled_ff   <= '0;
         e_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         u_ff         <= u_in;
         s1_valid_ff  <= s1_valid_in;
         first_ff     <= first_in;
         found_ff     <= found_in;
         settled_ff   <= settled_in;
         e_ff         <= e_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_u_ff     <= s1_u_in;
      cur_v_ff    <= cur_v_in;
      cur_dist_ff <= cur_dist_in;
      best_ff     <= best_in;
      next_ff     <= next_in;
      start_ff    <= start_in;
      out_word_ff <= out_word_in;
      if (s1_valid_ff) begin
         dist_ff[s1_u_ff] <= new_d;
      end
      if (relax) begin
         pred_ff[s1_u_ff] <= cur_v_ff;
      end
   end

   assign status.clear_done = (clr_ff == LAST_ADDR);
   assign status.start_ok   = ({1'b0, req_word.start_vertex} < n_used);
   assign status.scan_done  = (u_ff == n_used) && !s1_valid_ff;
   assign status.found      = found_ff;
   assign status.emit_done  = (e_ff == n_used - CNT_W'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = out_word_ff;

   // The vertex whose edges are being scanned has always been settled.
   a_scan_from_settled: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> settled_ff[cur_v_ff])
      else $error("scan runs from a vertex that is not settled");

   // After the first pass the scanned vertex was chosen below the limit.
   a_cur_below_limit: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !first_ff) |-> (cur_dist_ff < limit_ff))
      else $error("scanned vertex distance is not below the limit");

   // A reachable result carries a distance below the limit.
   a_reach_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_word_ff.reachable) |-> (out_word_ff.distance < limit_ff))
      else $error("reachable result at or above the limit");

   // An unreachable result reports the limit and predecessor zero.
   a_unreach_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_word_ff.reachable) |->
      ((out_word_ff.distance == limit_ff) && (out_word_ff.predecessor == '0)))
      else $error("unreachable result has a bad distance or predecessor");

   // A new search is loaded only while no scan word is in flight.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.load_run |=> (!s1_valid_ff && (u_ff == '0)))
      else $error("search loaded over a running scan");

endmodule

FILE: hw/rtl/dijkstra_shortest_paths.sv
// Top level of the single-source shortest path search over a stored adjacency matrix.
//
//   Channel   Direction  Handshake        Word
//   req_ch    in         valid / ready    opcode, row, col, weight, start_vertex
//   rsp_ch    out        valid / ready    vertex, reachable, distance, predecessor, last
//   csr_*     in         write enable     csr_index, csr_wdata (no read-back)
//
// After reset the adjacency memory is cleared one entry per cycle, all MAX_VERTICES squared
// entries, and req_ch.ready stays low; configuration writes are taken throughout.
// An edge write word leaves the block idle and ready for the next word. A search with n
// vertices in use runs one scan pass per settled vertex, at most n passes, each bounded by
// the single adjacency read port; then emission steps through the n vertices, giving the
// n - 1 result words, since the start vertex takes a step of its own but gives no word.
// The result register lets the search finish while a word waits; rsp_ch.ready low stalls
// only the emission of further words. A search whose start is not in use yields no words.
module dijkstra_shortest_paths #(
   parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   dsp_req_if.sink                          req_ch,
   dsp_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [dsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dsp_pkg::*;

   req_word_type     req_word;
   rsp_word_type     rsp_word;
   ctl_cmd_type      cmd;
   ctl_status_type   status;
   logic             rsp_valid;

   // Gather the request word into one bundle for the datapath.
   assign req_word.opcode       = opcode_type'(req_ch.opcode);
   assign req_word.row          = req_ch.row;
   assign req_word.col          = req_ch.col;
   assign req_word.weight       = req_ch.weight;
   assign req_word.start_vertex = req_ch.start_vertex;

   // The controller sequences clearing, edge writes, the scan passes and emission.
   dsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_word.opcode),
      .req_ready  (req_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the matrix, the distance tables and the result register.
   dsp_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_word   (req_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

   // Drive the result channel straight from the result register.
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.vertex      = rsp_word.vertex;
   assign rsp_ch.reachable   = rsp_word.reachable;
   assign rsp_ch.distance    = rsp_word.distance;
   assign rsp_ch.predecessor = rsp_word.predecessor;
   assign rsp_ch.last        = rsp_word.last;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the shortest path search block: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
   import dsp_pkg::*;

   // Half of the 12 ns clock period.
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 8;

   // A full search with 16 vertices runs up to 16 scan passes and gives 15 result words.
   // Once the last expected word has arrived, this many cycles also let an ignored search
   // or a trailing edge write finish before the registers are touched.
   localparam int SETTLE_CYCLES = 320;

   // Watchdog limit for a whole run.
   localparam int CYCLE_LIMIT = 1000000;

   // Length of the long receiver hold-off in the backpressure test.
   localparam int HOLD_OFF_CYCLES = 3000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dsp_req_if req_ch ();
   dsp_rsp_if rsp_ch ();

   dijkstra_shortest_paths DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the block's state: the edge matrix and the two registers.
   logic [DIST_W-1:0] edge_weight [FIELD_SPAN][FIELD_SPAN];
   logic [DIST_W-1:0] limit_reg;
   logic [CNT_W-1:0] count_reg;

   // Result words still owed by the block, oldest first.
   rsp_word_type pending_paths [$];
   rsp_word_type oldest_path;

   int error_count = 0;
   int cycle_count = 0;

   // Idle percentages of the sender and the receiver for the current phase.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // The test bumps hold_requests; the receiver process then counts out the hold-off.
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always #HALF_PERIOD clock = ~clock;

   // Watchdog: a run that hangs is a failed run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver. Ready is driven at the clock edge; during a requested hold-off it stays low
   // for the whole count, otherwise it drops at random at the phase's stall rate.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Vertices that actually take part in a search: the register clamped to [2, 16].
   function automatic int used_count();
      int n;
      int cap;
      n = count_reg;
      cap = (MAX_VERTICES_DEF < FIELD_SPAN) ? MAX_VERTICES_DEF : FIELD_SPAN;
      if (n < COUNT_MIN) n = COUNT_MIN;
      if (n > cap) n = cap;
      return n;
   endfunction

   // Runs the whole search from the given start on the local matrix and queues one result
   // word per vertex in use other than the start, in ascending vertex order. Ties between
   // equal tentative distances go to the lowest vertex, and an edge only replaces a
   // distance that it strictly improves. Anything at or above the limit is unreachable.
   function automatic void compute_shortest_paths(logic [VIDX_W-1:0] start);
      int n;
      int v;
      int u;
      int nxt;
      int last_u;
      logic [DIST_W-1:0] tent_dist [FIELD_SPAN];
      logic [VIDX_W-1:0] pred [FIELD_SPAN];
      bit done [FIELD_SPAN];
      logic [DIST_W:0] reach_sum;
      logic [DIST_W-1:0] best;
      bit found;
      bit active;
      rsp_word_type path;
      n = used_count();
      if (start >= n) return;
      for (u = 0; u < n; u++) begin
         tent_dist[u] = limit_reg;
         done[u] = 1'b0;
         pred[u] = '0;
      end
      tent_dist[start] = '0;
      done[start] = 1'b1;
      v = start;
      active = 1'b1;
      while (active) begin
         // Relax every unsettled neighbor of the vertex settled last.
         for (u = 0; u < n; u++) begin
            if (edge_weight[v][u] != '0 && !done[u]) begin
               reach_sum = {1'b0, tent_dist[v]} + {1'b0, edge_weight[v][u]};
               if ({1'b0, tent_dist[u]} > reach_sum) begin
                  tent_dist[u] = reach_sum[DIST_W-1:0];
                  pred[u] = VIDX_W'(v);
               end
            end
         end
         // Pick the closest unsettled vertex below the limit.
         best = limit_reg;
         found = 1'b0;
         nxt = 0;
         for (u = 0; u < n; u++) begin
            if (!done[u] && tent_dist[u] < best) begin
               best = tent_dist[u];
               nxt = u;
               found = 1'b1;
            end
         end
         if (found) begin
            done[nxt] = 1'b1;
            v = nxt;
         end else begin
            active = 1'b0;
         end
      end
      last_u = (start == n - 1) ? n - 2 : n - 1;
      for (u = 0; u < n; u++) begin
         if (u != start) begin
            path.vertex = VIDX_W'(u);
            path.reachable = done[u];
            path.distance = done[u] ? tent_dist[u] : limit_reg;
            path.predecessor = done[u] ? pred[u] : '0;
            path.last = (u == last_u);
            pending_paths.push_back(path);
         end
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s of vertex %0d wrong, expected %0d, actual %0d",
                  $time, name, oldest_path.vertex, want, got);
         error_count++;
      end
   endfunction

   // Scoreboard. Every accepted result word is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_paths.size() == 0) begin
            $display("%0t ns: unexpected result word, expected none, actual vertex %0d",
                     $time, rsp_ch.vertex);
            error_count++;
         end else begin
            oldest_path = pending_paths.pop_front();
            check_field("vertex", oldest_path.vertex, rsp_ch.vertex);
            check_field("reachable", oldest_path.reachable, rsp_ch.reachable);
            check_field("distance", oldest_path.distance, rsp_ch.distance);
            check_field("predecessor", oldest_path.predecessor, rsp_ch.predecessor);
            check_field("last", oldest_path.last, rsp_ch.last);
         end
      end
   end

   // An edge write word; the start field is unused and gets random content.
   function automatic req_word_type edge_word(logic [VIDX_W-1:0] src, logic [VIDX_W-1:0] dst,
                                              logic [DIST_W-1:0] weight);
      req_word_type word;
      word.opcode = OP_WRITE;
      word.row = src;
      word.col = dst;
      word.weight = weight;
      word.start_vertex = VIDX_W'($urandom);
      return word;
   endfunction

   // A search word; the edge fields are unused and get random content.
   function automatic req_word_type search_word(logic [VIDX_W-1:0] start);
      req_word_type word;
      word.opcode = OP_RUN;
      word.row = VIDX_W'($urandom);
      word.col = VIDX_W'($urandom);
      word.weight = DIST_W'($urandom);
      word.start_vertex = start;
      return word;
   endfunction

   // Offers one word and returns at the edge where it is taken. Valid is left high, so
   // back-to-back words go out without a gap. A random gap lowers valid first, and the
   // raise then falls on a later edge.
   task automatic send_word(req_word_type word);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= word.opcode;
      req_ch.row <= word.row;
      req_ch.col <= word.col;
      req_ch.weight <= word.weight;
      req_ch.start_vertex <= word.start_vertex;
      do @(posedge clock); while (!req_ch.ready);
      if (word.opcode == OP_WRITE)
         edge_weight[word.row][word.col] = word.weight;
      else
         compute_shortest_paths(word.start_vertex);
   endtask

   // Stops offering words, waits for every owed result and lets the block go quiet.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_paths.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the block is idle. The enable is lowered after the count write
   // and settles before the task returns, so a following call never raises it in the same step.
   task automatic apply_settings(logic [CSR_DATA_W-1:0] limit, logic [CSR_DATA_W-1:0] count);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= REG_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      limit_reg = limit[DIST_W-1:0];
      csr_index <= REG_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      count_reg = count[CNT_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Right after reset the matrix is empty, so nothing is reachable from anywhere.
   task automatic test_reset_state();
      send_word(search_word(4'd0));
      send_word(search_word(4'd15));
   endtask

   // Tie-breaking, strict improvement, self loops, over-limit edges and edge removal.
   task automatic test_edge_rules();
      send_word(edge_word(4'd0, 4'd1, 16'd5));
      send_word(edge_word(4'd1, 4'd2, 16'd3));
      // Equal to the path through vertex 1, so vertex 2 keeps vertex 0 as predecessor.
      send_word(edge_word(4'd0, 4'd2, 16'd8));
      // Vertices 4 and 5 tie at distance 2; vertex 4 settles first and claims vertex 6.
      send_word(edge_word(4'd0, 4'd4, 16'd2));
      send_word(edge_word(4'd0, 4'd5, 16'd2));
      send_word(edge_word(4'd4, 4'd6, 16'd1));
      send_word(edge_word(4'd5, 4'd6, 16'd1));
      // A self loop must not disturb anything.
      send_word(edge_word(4'd3, 4'd3, 16'd7));
      // Far beyond the limit, so vertex 3 stays out of reach.
      send_word(edge_word(4'd2, 4'd3, 16'hFFFF));
      send_word(edge_word(4'd15, 4'd0, 16'd1));
      // An edge that is written and then removed again.
      send_word(edge_word(4'd9, 4'd10, 16'd4));
      send_word(edge_word(4'd9, 4'd10, 16'd0));
      send_word(search_word(4'd0));
      send_word(search_word(4'd15));
      send_word(search_word(4'd9));
   endtask

   // Vertex counts inside and outside the legal range, and starts outside the graph.
   task automatic test_vertex_count();
      // Only the low five bits count: this selects three vertices.
      apply_settings(16'd1000, 16'hFFE3);
      send_word(search_word(4'd5));
      send_word(search_word(4'd0));
      // Zero is raised to two vertices.
      apply_settings(16'd1000, 16'd0);
      send_word(search_word(4'd1));
      send_word(search_word(4'd2));
      // Anything above sixteen is cut to sixteen.
      apply_settings(16'd1000, 16'd31);
      send_word(search_word(4'd0));
   endtask

   // Limits of zero and one reach nothing; the top limit is checked right at its edge.
   task automatic test_limit_extremes();
      apply_settings(16'd0, 16'd16);
      send_word(search_word(4'd0));
      apply_settings(16'd1, 16'd16);
      send_word(search_word(4'd0));
      apply_settings(16'hFFFF, 16'd16);
      send_word(edge_word(4'd11, 4'd12, 16'hFFFE));
      // The path to vertex 13 adds up to exactly the limit and does not count.
      send_word(edge_word(4'd12, 4'd13, 16'd1));
      send_word(edge_word(4'd11, 4'd14, 16'hFFFF));
      send_word(search_word(4'd11));
   endtask

   // The receiver holds off for a long stretch while searches keep coming, so the result
   // register fills, the block stops accepting words and has to recover cleanly.
   task automatic test_backpressure();
      int i;
      apply_settings(16'd1000, 16'd16);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (i = 0; i < 8; i++)
         send_word(edge_word(VIDX_W'(i), VIDX_W'(i + 1), DIST_W'($urandom_range(1, 9))));
      hold_requests++;
      for (i = 0; i < 10; i++)
         send_word(search_word(VIDX_W'($urandom)));
   endtask

   // One random phase: bursts of edge writes, each followed by a search. Most vertices
   // lie inside the graph in use and most weights are small, so that real paths form;
   // the rest are far vertices, removals, huge weights, weights at the limit or half of it.
   task automatic run_random_phase(logic [CSR_DATA_W-1:0] limit, logic [CSR_DATA_W-1:0] count,
                                   int sender_idle, int receiver_stall, int items);
      int sent;
      int n;
      int pick;
      logic [VIDX_W-1:0] src;
      logic [VIDX_W-1:0] dst;
      logic [VIDX_W-1:0] start;
      logic [DIST_W-1:0] weight;
      apply_settings(limit, count);
      send_idle_pct = sender_idle;
      rsp_stall_pct = receiver_stall;
      n = used_count();
      sent = 0;
      while (sent < items) begin
         repeat ($urandom_range(1, 6)) begin
            src = ($urandom_range(9) == 0) ? VIDX_W'($urandom) : VIDX_W'($urandom_range(n - 1));
            dst = ($urandom_range(9) == 0) ? VIDX_W'($urandom) : VIDX_W'($urandom_range(n - 1));
            pick = $urandom_range(99);
            if (pick < 55)
               weight = DIST_W'($urandom_range(1, 15));
            else if (pick < 70)
               weight = '0;
            else if (pick < 85)
               weight = DIST_W'($urandom);
            else if (pick < 93)
               weight = limit_reg - DIST_W'($urandom_range(0, 2));
            else
               weight = (limit_reg >> 1) + DIST_W'($urandom_range(0, 1));
            send_word(edge_word(src, dst, weight));
            sent++;
         end
         start = ($urandom_range(9) == 0) ? VIDX_W'($urandom) : VIDX_W'($urandom_range(n - 1));
         send_word(search_word(start));
         // A search from outside the graph is dropped by the block and is not counted.
         if (start < n) sent++;
      end
   endtask

   // The four idle phases, each with its own register setting.
   task automatic test_random_traffic();
      run_random_phase(16'd1000, 16'd16, 0, 0, 90);
      run_random_phase(16'hFFFF, 16'd9, 54, 0, 90);
      run_random_phase(16'd45, 16'd5, 0, 54, 90);
      run_random_phase(16'd300, 16'd2, 7, 7, 40);
   endtask

   initial begin
      int r;
      int c;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_LIMIT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_WRITE;
      req_ch.row = '0;
      req_ch.col = '0;
      req_ch.weight = '0;
      req_ch.start_vertex = '0;
      rsp_ch.ready = 1'b0;
      for (r = 0; r < FIELD_SPAN; r++)
         for (c = 0; c < FIELD_SPAN; c++)
            edge_weight[r][c] = '0;
      limit_reg = LIMIT_RESET;
      count_reg = COUNT_RESET;

      // Reset once. The block then clears its matrix with ready low; the first word
      // simply waits for the handshake.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_edge_rules();
      test_vertex_count();
      test_limit_extremes();
      test_backpressure();
      test_random_traffic();

      drain_results();
      if (error_count == 0 && pending_paths.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/dsp_pkg.sv
hw/rtl/dsp_if.sv
hw/rtl/dsp_ctrl.sv
hw/rtl/dsp_datapath.sv
hw/rtl/dijkstra_shortest_paths.sv
tb/sv/tb_top.sv
